// ===== hdl/serial_time_sync_clock_reporter_assert.svh =====
// Assertion macros used by the checker file of the clock reporter.
`ifndef SERIAL_TIME_SYNC_CLOCK_REPORTER_ASSERT_SVH
`define SERIAL_TIME_SYNC_CLOCK_REPORTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define STSCR_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define STSCR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/stscr_pkg.sv =====
// Types, constants and helper functions of the serial time-sync clock reporter.
package stscr_pkg;

    localparam int BUFFER_DEPTH_DEF  = 14;
    localparam int MESSAGE_CHARS_DEF = 9;
    localparam int TIME_CHARS        = 8;
    localparam int REP_LEN           = 17;
    localparam int REP_HUND          = 10;
    localparam int REP_LAST          = 16;
    localparam int TEMP_SCALE        = 330;
    localparam int TEMP_W            = 9;
    localparam int ADC_W             = 12;
    localparam int PROD_W            = ADC_W + TEMP_W;

    localparam logic [7:0] CHR_STAR  = 8'h2A;
    localparam logic [7:0] CHR_HASH  = 8'h23;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_T     = 8'h54;
    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_S     = 8'h53;
    localparam logic [7:0] CHR_B     = 8'h42;
    localparam logic [7:0] CHR_BANG  = 8'h21;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_NUL   = 8'h00;

    typedef enum logic [1:0] {
        KIND_REPORT = 2'd0,
        KIND_SYNC   = 2'd1,
        KIND_MSG    = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIGITS,
        ST_REPORT,
        ST_SYNC,
        ST_MSG
    } state_t;

    typedef struct packed {
        logic                 action;
        logic [7:0]           rx_byte;
        logic [ADC_W-1:0]     adc_sample;
        logic                 button_pressed;
    } req_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       last;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } rsp_t;

    typedef struct packed {
        logic  store;
        logic  sync;
        logic  flush;
        logic  msg_start;
        logic  tick;
        logic  digits;
        logic  rep_adv;
        logic  msg_adv;
        kind_t emit;
    } cmd_t;

    typedef struct packed {
        logic action;
        logic is_star;
        logic is_hash;
        logic sync_ok;
        logic nonempty;
        logic running;
        logic rep_last;
        logic msg_last;
    } stat_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHR_ZERO) && (c <= CHR_NINE);
    endfunction

    function automatic logic [6:0] two_digit(input logic [7:0] hi, input logic [7:0] lo);
        return 7'(hi[3:0]) * 7'd10 + 7'(lo[3:0]);
    endfunction

    // quotient by ten via reciprocal, exact below 128
    function automatic logic [3:0] div10(input logic [6:0] v);
        logic [14:0] p;
        p = 15'(v) * 15'd205;
        return p[14:11];
    endfunction

    function automatic logic [3:0] mod10(input logic [6:0] v);
        logic [6:0] r;
        r = v - 7'(div10(v)) * 7'd10;
        return r[3:0];
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        return {4'h3, d};
    endfunction

endpackage

// ===== hdl/stscr_ctrl.sv =====
// Controller state machine: sequences one item at a time and drives the datapath.
module stscr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    input  stscr_pkg::stat_t stat,
    output stscr_pkg::cmd_t  cmd
);
    import stscr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.emit   = KIND_REPORT;
        req_ready  = 1'b0;
        rsp_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (stat.action)
                    begin
                        if (stat.running)
                        begin
                            cmd.tick   = 1'b1;
                            state_next = ST_DIGITS;
                        end
                    end
                    else if (stat.is_star)
                    begin
                        cmd.sync = 1'b1;
                        if (stat.sync_ok)
                        begin
                            state_next = ST_SYNC;
                        end
                    end
                    else if (stat.is_hash)
                    begin
                        cmd.flush = 1'b1;
                        if (stat.nonempty)
                        begin
                            cmd.msg_start = 1'b1;
                            state_next    = ST_MSG;
                        end
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                    end
                end
            end
            ST_DIGITS:
            begin
                cmd.digits = 1'b1;
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                rsp_valid = 1'b1;
                cmd.emit  = KIND_REPORT;
                if (rsp_ready)
                begin
                    if (stat.rep_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.rep_adv = 1'b1;
                    end
                end
            end
            ST_SYNC:
            begin
                rsp_valid = 1'b1;
                cmd.emit  = KIND_SYNC;
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MSG:
            begin
                rsp_valid = 1'b1;
                cmd.emit  = KIND_MSG;
                if (rsp_ready)
                begin
                    if (stat.msg_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.msg_adv = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/stscr_dp.sv =====
// Datapath: clock counters, character buffer, temperature scaling and beat formatting.
module stscr_dp #(
    parameter int BUFFER_DEPTH  = stscr_pkg::BUFFER_DEPTH_DEF,
    parameter int MESSAGE_CHARS = stscr_pkg::MESSAGE_CHARS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  stscr_pkg::req_t  req,
    input  stscr_pkg::cmd_t  cmd,
    output stscr_pkg::stat_t stat,
    output stscr_pkg::rsp_t  rsp
);
    import stscr_pkg::*;

    // only the leading entries are ever read back
    localparam int KEEP   = (MESSAGE_CHARS > TIME_CHARS) ? MESSAGE_CHARS : TIME_CHARS;
    localparam int KEEP_W = $clog2(KEEP);
    localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);
    localparam int REP_W  = $clog2(REP_LEN);

    logic [4:0]        hours_reg, hours_next;
    logic [5:0]        minutes_reg, minutes_next;
    logic [5:0]        seconds_reg, seconds_next;
    logic              running_reg, running_next;
    logic [7:0]        buf_reg [KEEP];
    logic [7:0]        buf_next [KEEP];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] msg_cnt_reg, msg_cnt_next;
    logic [FILL_W-1:0] msg_idx_reg, msg_idx_next;
    logic [REP_W-1:0]  rep_idx_reg, rep_idx_next;
    logic [TEMP_W-1:0] temp_reg, temp_next;
    logic              btn_reg, btn_next;
    logic              hot_reg, hot_next;
    logic [7:0]        rep_reg [REP_LEN];
    logic [7:0]        rep_next [REP_LEN];

    logic [6:0]        h_val, m_val, s_val;
    logic              digits_ok;
    logic              sync_ok;
    logic [PROD_W-1:0] prod;
    logic [1:0]        t_hund;
    logic [6:0]        t_rem;
    logic              rep_last;
    logic              msg_last;

    assign h_val = two_digit(buf_reg[0], buf_reg[1]);
    assign m_val = two_digit(buf_reg[3], buf_reg[4]);
    assign s_val = two_digit(buf_reg[6], buf_reg[7]);
    assign digits_ok = is_digit(buf_reg[0]) && is_digit(buf_reg[1]) &&
                       is_digit(buf_reg[3]) && is_digit(buf_reg[4]) &&
                       is_digit(buf_reg[6]) && is_digit(buf_reg[7]);
    assign sync_ok = digits_ok && (h_val < 7'd24) && (m_val < 7'd60) && (s_val < 7'd60);

    assign prod = PROD_W'(req.adc_sample) * PROD_W'(TEMP_SCALE);

    always_comb
    begin
        if (temp_reg >= TEMP_W'(300))
        begin
            t_hund = 2'd3;
            t_rem  = 7'(temp_reg - TEMP_W'(300));
        end
        else if (temp_reg >= TEMP_W'(200))
        begin
            t_hund = 2'd2;
            t_rem  = 7'(temp_reg - TEMP_W'(200));
        end
        else if (temp_reg >= TEMP_W'(100))
        begin
            t_hund = 2'd1;
            t_rem  = 7'(temp_reg - TEMP_W'(100));
        end
        else
        begin
            t_hund = 2'd0;
            t_rem  = 7'(temp_reg);
        end
    end

    assign rep_last = (rep_idx_reg == REP_W'(REP_LAST));
    assign msg_last = (msg_idx_reg == FILL_W'(MESSAGE_CHARS - 1));

    always_comb
    begin
        hours_next   = hours_reg;
        minutes_next = minutes_reg;
        seconds_next = seconds_reg;
        running_next = running_reg;
        buf_next     = buf_reg;
        fill_next    = fill_reg;
        msg_cnt_next = msg_cnt_reg;
        msg_idx_next = msg_idx_reg;
        rep_idx_next = rep_idx_reg;
        temp_next    = temp_reg;
        btn_next     = btn_reg;
        hot_next     = hot_reg;
        rep_next     = rep_reg;

        if (cmd.tick)
        begin
            if (seconds_reg == 6'd59)
            begin
                seconds_next = '0;
                if (minutes_reg == 6'd59)
                begin
                    minutes_next = '0;
                    hours_next   = (hours_reg == 5'd23) ? 5'd0 : hours_reg + 5'd1;
                end
                else
                begin
                    minutes_next = minutes_reg + 6'd1;
                end
            end
            else
            begin
                seconds_next = seconds_reg + 6'd1;
            end
            temp_next    = prod[PROD_W-1 -: TEMP_W];
            btn_next     = req.button_pressed;
            rep_idx_next = '0;
        end

        if (cmd.sync)
        begin
            fill_next = '0;
            if (sync_ok)
            begin
                hours_next   = h_val[4:0];
                minutes_next = m_val[5:0];
                seconds_next = s_val[5:0];
                running_next = 1'b1;
            end
        end

        if (cmd.flush)
        begin
            fill_next = '0;
        end

        if (cmd.msg_start)
        begin
            msg_cnt_next = fill_reg;
            msg_idx_next = '0;
        end

        if (cmd.store && (fill_reg < FILL_W'(BUFFER_DEPTH)))
        begin
            fill_next = fill_reg + FILL_W'(1);
            if (fill_reg < FILL_W'(KEEP))
            begin
                buf_next[fill_reg[KEEP_W-1:0]] = req.rx_byte;
            end
        end

        if (cmd.digits)
        begin
            hot_next     = (t_hund != 2'd0);
            rep_next[0]  = CHR_T;
            rep_next[1]  = digit_char(div10(7'(hours_reg)));
            rep_next[2]  = digit_char(mod10(7'(hours_reg)));
            rep_next[3]  = CHR_COLON;
            rep_next[4]  = digit_char(div10(7'(minutes_reg)));
            rep_next[5]  = digit_char(mod10(7'(minutes_reg)));
            rep_next[6]  = CHR_COLON;
            rep_next[7]  = digit_char(div10(7'(seconds_reg)));
            rep_next[8]  = digit_char(mod10(7'(seconds_reg)));
            rep_next[9]  = CHR_S;
            rep_next[10] = digit_char(4'(t_hund));
            rep_next[11] = digit_char(div10(t_rem));
            rep_next[12] = digit_char(mod10(t_rem));
            rep_next[13] = CHR_B;
            rep_next[14] = digit_char(4'(btn_reg));
            rep_next[15] = CHR_BANG;
            rep_next[16] = CHR_LF;
        end

        if (cmd.rep_adv)
        begin
            // hundreds digit is skipped when the reading is not hot (below 100)
            if ((rep_idx_reg == REP_W'(REP_HUND - 1)) && !hot_reg)
            begin
                rep_idx_next = REP_W'(REP_HUND + 1);
            end
            else
            begin
                rep_idx_next = rep_idx_reg + REP_W'(1);
            end
        end

        if (cmd.msg_adv)
        begin
            msg_idx_next = msg_idx_reg + FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hours_reg   <= '0;
            minutes_reg <= '0;
            seconds_reg <= '0;
            running_reg <= 1'b0;
            fill_reg    <= '0;
            msg_idx_reg <= '0;
            rep_idx_reg <= '0;
            hot_reg     <= 1'b0;
            for (int i = 0; i < KEEP; i++)
            begin
                buf_reg[i] <= '0;
            end
        end
        else
        begin
            hours_reg   <= hours_next;
            minutes_reg <= minutes_next;
            seconds_reg <= seconds_next;
            running_reg <= running_next;
            fill_reg    <= fill_next;
            msg_idx_reg <= msg_idx_next;
            rep_idx_reg <= rep_idx_next;
            hot_reg     <= hot_next;
            buf_reg     <= buf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        msg_cnt_reg <= msg_cnt_next;
        temp_reg    <= temp_next;
        btn_reg     <= btn_next;
        rep_reg     <= rep_next;
    end

    always_comb
    begin
        stat.action   = req.action;
        stat.is_star  = (req.rx_byte == CHR_STAR);
        stat.is_hash  = (req.rx_byte == CHR_HASH);
        stat.sync_ok  = sync_ok;
        stat.nonempty = (fill_reg != '0);
        stat.running  = running_reg;
        stat.rep_last = rep_last;
        stat.msg_last = msg_last;
    end

    always_comb
    begin
        rsp.kind    = cmd.emit;
        rsp.hours   = hours_reg;
        rsp.minutes = minutes_reg;
        rsp.seconds = seconds_reg;
        case (cmd.emit)
            KIND_REPORT:
            begin
                rsp.data_byte = rep_reg[rep_idx_reg];
                rsp.last      = rep_last;
            end
            KIND_SYNC:
            begin
                rsp.data_byte = CHR_NUL;
                rsp.last      = 1'b1;
            end
            KIND_MSG:
            begin
                rsp.data_byte = (msg_idx_reg < msg_cnt_reg) ?
                                buf_reg[msg_idx_reg[KEEP_W-1:0]] : CHR_SPACE;
                rsp.last      = msg_last;
            end
            default:
            begin
                rsp.data_byte = CHR_NUL;
                rsp.last      = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/serial_time_sync_clock_reporter.sv =====
// Top level of the serial time-sync clock reporter.
//
// req channel (valid/ready): one beat per received serial byte or per one-second tick.
// rsp channel (valid/ready): result beats; last marks the final beat of an item's run.
// One item is worked at a time; req_ready is high only while no item is in progress.
// A plain byte, a rejected '*', a '#' on an empty buffer and a tick before the clock
// is set give no beat.
// An accepted '*' gives one beat on the next cycle.
// A '#' gives MESSAGE_CHARS beats, one per cycle while rsp_ready is high, from the cycle after acceptance.
// A tick passes through the digit formatting register stage, then gives 16 beats
// (17 when the temperature reads 100 or more), one per cycle while rsp_ready is high.
// Report beats are read from the single formatted-report register, one byte a cycle while rsp_ready is high.
// When rsp_ready is low the current beat holds and the sequencer waits.
// Reset clears the clock to 00:00:00, stops it, empties and zeroes the buffer.
module serial_time_sync_clock_reporter #(
    parameter int BUFFER_DEPTH  = stscr_pkg::BUFFER_DEPTH_DEF,
    parameter int MESSAGE_CHARS = stscr_pkg::MESSAGE_CHARS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  stscr_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output stscr_pkg::rsp_t rsp
);
    import stscr_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    stscr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    stscr_dp #(
        .BUFFER_DEPTH  (BUFFER_DEPTH),
        .MESSAGE_CHARS (MESSAGE_CHARS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

// ===== hdl/stscr_checker.sv =====
// Port-level checker for the clock reporter and its bind.
`include "serial_time_sync_clock_reporter_assert.svh"

module stscr_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_ready,
    input stscr_pkg::req_t req,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input stscr_pkg::rsp_t rsp
);
    import stscr_pkg::*;

    `STSCR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp beat changed while stalled")
    `STSCR_ASSERT_NOW(a_one_item, req_ready, !rsp_valid, "new item taken while beats are pending")
    `STSCR_ASSERT_NOW(a_clock_range, rsp_valid, (rsp.hours < 5'd24) && (rsp.minutes < 6'd60) && (rsp.seconds < 6'd60), "clock value out of range")
    `STSCR_ASSERT_NOW(a_sync_beat, rsp_valid && (rsp.kind == KIND_SYNC), rsp.last && (rsp.data_byte == CHR_NUL), "malformed time-accepted beat")
    `STSCR_ASSERT_NOW(a_report_end, rsp_valid && (rsp.kind == KIND_REPORT) && rsp.last, rsp.data_byte == CHR_LF, "report does not end in newline")

endmodule

bind serial_time_sync_clock_reporter stscr_checker u_stscr_checker (.*);

// ===== verif/tb.sv =====
// Testbench for the serial time-sync clock reporter: directed and random beats against a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stscr_pkg::*;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    serial_time_sync_clock_reporter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // predicted block state
    int unsigned clk_hrs = 0;
    int unsigned clk_min = 0;
    int unsigned clk_sec = 0;
    logic        clk_running = 1'b0;
    logic [7:0]  rx_store [BUFFER_DEPTH_DEF] = '{default: 8'h00};
    int unsigned fill = 0;

    req_t item_q [$];
    rsp_t beat_q [$];
    int   n_queued = 0;
    int   n_accepted = 0;
    int   n_err = 0;
    int   calm_from = 32'h7fff_ffff;
    logic calm;
    logic long_stall_req = 1'b0;
    logic long_stall_done;
    int   send_gap;
    int   rdy_hold;

    assign calm = (n_accepted >= calm_from);

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic numeral(input logic [7:0] c);
        return (c >= CHR_ZERO) && (c <= CHR_NINE);
    endfunction

    function automatic int unsigned pair_value(input logic [7:0] hi, input logic [7:0] lo);
        return int'(hi - CHR_ZERO) * 10 + int'(lo - CHR_ZERO);
    endfunction

    function automatic logic [7:0] dchar(input int unsigned v);
        return CHR_ZERO + 8'(v);
    endfunction

    function automatic rsp_t beat(input kind_t k, input logic [7:0] d, input logic l);
        rsp_t r;
        r.kind      = k;
        r.data_byte = d;
        r.last      = l;
        r.hours     = 5'(clk_hrs);
        r.minutes   = 6'(clk_min);
        r.seconds   = 6'(clk_sec);
        return r;
    endfunction

    task automatic predict_item(input req_t it);
        logic [7:0]  text [$];
        int unsigned degc;
        int unsigned hh;
        int unsigned mm;
        int unsigned ss;
        int unsigned cnt;
        logic        digits_ok;
        if (it.action)
        begin
            if (!clk_running)
                return;
            clk_sec++;
            if (clk_sec > 59)
            begin
                clk_sec = 0;
                clk_min++;
            end
            if (clk_min > 59)
            begin
                clk_min = 0;
                clk_hrs++;
            end
            if (clk_hrs > 23)
                clk_hrs = 0;
            degc = (32'(it.adc_sample) * 330) >> 12;
            text.push_back(CHR_T);
            text.push_back(dchar(clk_hrs / 10));
            text.push_back(dchar(clk_hrs % 10));
            text.push_back(CHR_COLON);
            text.push_back(dchar(clk_min / 10));
            text.push_back(dchar(clk_min % 10));
            text.push_back(CHR_COLON);
            text.push_back(dchar(clk_sec / 10));
            text.push_back(dchar(clk_sec % 10));
            text.push_back(CHR_S);
            if (degc >= 100)
                text.push_back(dchar(degc / 100));
            text.push_back(dchar((degc / 10) % 10));
            text.push_back(dchar(degc % 10));
            text.push_back(CHR_B);
            text.push_back(dchar(32'(it.button_pressed)));
            text.push_back(CHR_BANG);
            text.push_back(CHR_LF);
            foreach (text[i])
                beat_q.push_back(beat(KIND_REPORT, text[i], i == text.size() - 1));
        end
        else if (it.rx_byte == CHR_STAR)
        begin
            digits_ok = numeral(rx_store[0]) && numeral(rx_store[1]) &&
                        numeral(rx_store[3]) && numeral(rx_store[4]) &&
                        numeral(rx_store[6]) && numeral(rx_store[7]);
            fill = 0;
            if (digits_ok)
            begin
                hh = pair_value(rx_store[0], rx_store[1]);
                mm = pair_value(rx_store[3], rx_store[4]);
                ss = pair_value(rx_store[6], rx_store[7]);
                if (hh < 24 && mm < 60 && ss < 60)
                begin
                    clk_hrs     = hh;
                    clk_min     = mm;
                    clk_sec     = ss;
                    clk_running = 1'b1;
                    beat_q.push_back(beat(KIND_SYNC, CHR_NUL, 1'b1));
                end
            end
        end
        else if (it.rx_byte == CHR_HASH)
        begin
            cnt  = fill;
            fill = 0;
            if (cnt != 0)
                for (int i = 0; i < MESSAGE_CHARS_DEF; i++)
                    beat_q.push_back(beat(KIND_MSG, (i < cnt) ? rx_store[i] : CHR_SPACE,
                                          i == MESSAGE_CHARS_DEF - 1));
        end
        else if (fill < BUFFER_DEPTH_DEF)
        begin
            rx_store[fill] = it.rx_byte;
            fill++;
        end
    endtask

    task automatic note_mismatch(input string what, input rsp_t want, input rsp_t got);
        n_err++;
        if (n_err <= 10)
            $display({"%0t %s: exp kind=%0d data=%02h last=%0d %0d:%0d:%0d",
                      " got kind=%0d data=%02h last=%0d %0d:%0d:%0d"},
                     $time, what, want.kind, want.data_byte, want.last, want.hours,
                     want.minutes, want.seconds, got.kind, got.data_byte, got.last,
                     got.hours, got.minutes, got.seconds);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            send_gap  <= 0;
        end
        else if (!req_valid || req_ready)
        begin
            if (send_gap != 0)
            begin
                req_valid <= 1'b0;
                send_gap  <= send_gap - 1;
            end
            else if (item_q.size() != 0)
            begin
                req       <= item_q.pop_front();
                req_valid <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 6);
            end
            else
                req_valid <= 1'b0;
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready       <= 1'b0;
            rdy_hold        <= 0;
            long_stall_done <= 1'b0;
        end
        else if (rdy_hold != 0)
        begin
            rsp_ready <= 1'b0;
            rdy_hold  <= rdy_hold - 1;
        end
        else if (long_stall_req && !long_stall_done)
        begin
            rsp_ready       <= 1'b0;
            rdy_hold        <= 79;
            long_stall_done <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 6) == 0)
        begin
            rsp_ready <= 1'b0;
            rdy_hold  <= $urandom_range(0, 5);
        end
        else
            rsp_ready <= 1'b1;
    end

    // monitor: check result beats, then predict for the accepted item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (beat_q.size() == 0)
                    note_mismatch("unexpected beat", '0, rsp);
                else if (rsp !== beat_q[0])
                    note_mismatch("mismatch", beat_q.pop_front(), rsp);
                else
                    void'(beat_q.pop_front());
            end
            if (req_valid && req_ready)
            begin
                predict_item(req);
                n_accepted++;
            end
        end
    end

    task automatic queue_item(input logic act, input logic [7:0] ch, input logic [11:0] adc,
                              input logic btn);
        req_t it;
        it.action         = act;
        it.rx_byte        = ch;
        it.adc_sample     = adc;
        it.button_pressed = btn;
        item_q.push_back(it);
        n_queued++;
    endtask

    task automatic send_byte(input logic [7:0] ch);
        queue_item(1'b0, ch, 12'($urandom), 1'($urandom));
    endtask

    task automatic send_tick(input logic [11:0] adc, input logic btn);
        queue_item(1'b1, 8'($urandom), adc, btn);
    endtask

    task automatic send_text(input string s);
        foreach (s[i])
            send_byte(s[i]);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        c = 8'($urandom);
        while (c == CHR_STAR || c == CHR_HASH)
            c = 8'($urandom);
        return c;
    endfunction

    // wait until every item is taken and every result has come back
    task automatic settle();
        while (n_accepted != n_queued || beat_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned h;
        int unsigned m;
        int unsigned s;
        int unsigned len;
        int unsigned pick;
        int          rand_base;

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // tick while stopped, message and sync on an empty buffer
        queue_item(1'b1, 8'hff, 12'hfff, 1'b1);
        send_byte(CHR_HASH);
        send_byte(CHR_STAR);
        // extreme bytes, padded message
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(CHR_HASH);
        // separators are not checked
        send_text("23x59y59");
        send_byte(CHR_STAR);
        // full wrap, hottest reading with button
        send_tick(12'hfff, 1'b1);
        send_tick(12'h000, 1'b0);
        send_tick(12'd124, 1'b1);
        send_tick(12'd1241, 1'b0);
        send_tick(12'd1242, 1'b1);
        // stale buffer contents: hours 24 rejected, then 14 accepted
        send_text("24");
        send_byte(CHR_STAR);
        send_text("1");
        send_byte(CHR_STAR);
        send_tick(12'd2048, 1'b0);
        settle();

        // receiver holds off long while items keep coming
        long_stall_req = 1'b1;
        send_tick(12'($urandom), 1'($urandom));
        send_text("AB");
        send_byte(CHR_HASH);
        send_tick(12'($urandom), 1'($urandom));
        settle();

        rand_base = n_queued;
        while (n_queued - rand_base < 120)
        begin
            if (n_queued - rand_base >= 90 && calm_from == 32'h7fff_ffff)
                calm_from = n_queued;
            pick = $urandom_range(0, 99);
            if (pick < 35)
                send_tick(12'($urandom), 1'($urandom));
            else if (pick < 60)
            begin
                h = $urandom_range(0, 23);
                m = $urandom_range(0, 59);
                s = $urandom_range(0, 59);
                send_byte(dchar(h / 10));
                send_byte(dchar(h % 10));
                send_byte(plain_byte());
                send_byte(dchar(m / 10));
                send_byte(dchar(m % 10));
                send_byte(plain_byte());
                send_byte(dchar(s / 10));
                send_byte(dchar(s % 10));
                send_byte(CHR_STAR);
            end
            else if (pick < 70)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    h = $urandom_range(0, 99);
                    m = $urandom_range(0, 99);
                    s = $urandom_range(60, 99);
                    if ($urandom_range(0, 1) == 0)
                        h = $urandom_range(24, 99);
                    send_byte(dchar(h / 10));
                    send_byte(dchar(h % 10));
                    send_byte(plain_byte());
                    send_byte(dchar(m / 10));
                    send_byte(dchar(m % 10));
                    send_byte(plain_byte());
                    send_byte(dchar(s / 10));
                    send_byte(dchar(s % 10));
                end
                else
                begin
                    len = $urandom_range(0, 9);
                    repeat (len)
                        send_byte(($urandom_range(0, 2) == 0) ? plain_byte()
                                                              : dchar($urandom_range(0, 9)));
                end
                send_byte(CHR_STAR);
            end
            else if (pick < 90)
            begin
                len = $urandom_range(1, 16);
                repeat (len)
                    send_byte(plain_byte());
                send_byte(CHR_HASH);
            end
            else
                send_byte(8'($urandom));
        end
        settle();
        repeat (40) @(posedge clk);
        n_err += beat_q.size();
        if (n_err == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
